// ----- src/cmd_pkg.sv -----
`timescale 1ns / 1ps
package cmd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int DELAY_LENGTH = 2048;
  localparam int ADDR_W       = $clog2(DELAY_LENGTH);
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_W       = $clog2(SINE_ENTRIES);
  localparam int QTR_W        = SINE_W - 2;
  localparam int QTR_N        = SINE_ENTRIES / 4;
  localparam int MAG_W        = 15;
  localparam int GAIN_W       = 16;
  localparam int BASE_W       = 11;
  localparam int DEPTH_W      = 10;
  localparam int STEP_W       = 32;
  localparam int PHASE_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int PROD_W       = DEPTH_W + MAG_W;
  localparam int DLY_W        = BASE_W + 2;
  localparam int ACC_W        = SAMPLE_BITS + GAIN_W + 2;
  localparam int Q_W          = ACC_W - 15;
  localparam int CNT_W        = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP   = 3'd4;

  localparam logic [GAIN_W-1:0]  DRY_GAIN_RST   = 16'd16384;
  localparam logic [GAIN_W-1:0]  WET_GAIN_RST   = 16'd16384;
  localparam logic [BASE_W-1:0]  BASE_DELAY_RST = 11'd1323;
  localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST  = 10'd88;
  localparam logic [STEP_W-1:0]  LFO_STEP_RST   = 32'd24349;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_channel;
  } cmd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          frame_done;
  } cmd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWING,
    ST_ADDR,
    ST_FETCH,
    ST_MIX,
    ST_DONE
  } cmd_state_t;

  typedef logic [MAG_W-1:0] qs_tab_t [0:QTR_N-1];

  // quarter-wave sine, degree 9 odd polynomial in q30, scaled to q1.15
  function automatic logic [MAG_W-1:0] qsine_calc(input int m);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] acc;
    logic [63:0] s;
    u   = 64'(m) << (30 - QTR_W);
    u2  = (u * u) >> 30;
    acc = 64'd172272;
    acc = 64'd5026997 - ((acc * u2) >> 30);
    acc = 64'd85569306 - ((acc * u2) >> 30);
    acc = 64'd693598670 - ((acc * u2) >> 30);
    acc = 64'd1686629713 - ((acc * u2) >> 30);
    s   = (acc * u) >> 30;
    s   = (s * 64'd32767 + 64'd536870912) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[MAG_W-1:0];
  endfunction

  function automatic qs_tab_t build_qs_tab();
    qs_tab_t t;
    for (int m = 0; m < QTR_N; m++) begin
      t[m] = qsine_calc(m);
    end
    return t;
  endfunction

  localparam qs_tab_t          QS_TAB  = build_qs_tab();
  localparam logic [MAG_W-1:0] QS_PEAK = qsine_calc(QTR_N);

endpackage

// ----- src/chorus_modulated_delay_unit.sv -----
`timescale 1ns / 1ps
// Chorus effect: each accepted word is one sample; the block reads a 2048-entry delay
// line at a distance of base_delay plus mod_depth times a sine LFO, then mixes dry and
// delayed samples with Q1.15 gains, rounding and saturating. Each word goes through
// table lookup, a 10-step bit-serial multiply for the delay swing, delay memory
// access, and a 16-step bit-serial multiply for the mix; it takes no new word until
// these are done. The result sits in an output register, so the next word is taken while
// it waits. The delay line reads as zero until written; there is no clearing pass.
// Write configuration only while the block is idle.
module chorus_modulated_delay_unit
  import cmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cmd_in_t               in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cmd_out_t              out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_state_t state_r, state_nxt;

  logic [GAIN_W-1:0]  dry_gain_r, wet_gain_r;
  logic [BASE_W-1:0]  base_delay_r;
  logic [DEPTH_W-1:0] mod_depth_r;
  logic [STEP_W-1:0]  lfo_step_r;
  logic [PHASE_W-1:0] phase_r;
  logic [ADDR_W-1:0]  wp_r;
  logic               wrapped_r;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          last_r;
  logic [MAG_W-1:0]              mag_r;
  logic                          neg_r;
  logic [DEPTH_W-1:0]            depth_sh_r;
  logic [PROD_W-1:0]             prod_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [SAMPLE_BITS-1:0]        rdata_r;
  logic                          rd_ok_r;
  logic signed [SAMPLE_BITS-1:0] d_r;
  logic [GAIN_W-1:0]             dry_sh_r, wet_sh_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          out_valid_r;
  cmd_out_t                      out_word_r;

  logic [SAMPLE_BITS-1:0] mem [0:DELAY_LENGTH-1];

  logic                   accept;
  logic                   load_out;
  logic                   swing_last;
  logic                   mix_last;
  logic [SINE_W-1:0]      sidx;
  logic [QTR_W:0]         qidx;
  logic signed [DLY_W-1:0] swing;
  logic signed [DLY_W-1:0] dly_raw;
  logic [ADDR_W-1:0]      dly;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   rd_ok;
  logic signed [ACC_W-1:0] mix_add;
  logic signed [ACC_W-1:0] t_sum;
  logic signed [Q_W-1:0]   q_val;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

  assign accept     = in_valid && !in_stall;
  assign swing_last = (cnt_r == CNT_W'(DEPTH_W - 1));
  assign mix_last   = (cnt_r == CNT_W'(GAIN_W - 1));

  // sine index and quarter-wave fold
  assign sidx = phase_r[PHASE_W-1 -: SINE_W];
  assign qidx = sidx[QTR_W] ? ((QTR_W+1)'(QTR_N) - {1'b0, sidx[QTR_W-1:0]})
                            : {1'b0, sidx[QTR_W-1:0]};

  // delay and read address
  always_comb begin
    swing   = DLY_W'(prod_r[PROD_W-1 -: DEPTH_W]);
    swing   = neg_r ? -swing : swing;
    dly_raw = DLY_W'(base_delay_r) + swing;
    if (dly_raw < 0) begin
      dly = '0;
    end else if (dly_raw > DLY_W'(DELAY_LENGTH - 1)) begin
      dly = ADDR_W'(DELAY_LENGTH - 1);
    end else begin
      dly = dly_raw[ADDR_W-1:0];
    end
    rd_addr = wp_r - dly;
    rd_ok   = wrapped_r || (rd_addr < wp_r);
  end

  // mix step, round and saturate
  always_comb begin
    mix_add = '0;
    if (dry_sh_r[GAIN_W-1]) begin
      mix_add = mix_add + ACC_W'(x_r);
    end
    if (wet_sh_r[GAIN_W-1]) begin
      mix_add = mix_add + ACC_W'(d_r);
    end
    t_sum = acc_r + ACC_W'(16384);
    q_val = Q_W'(t_sum >>> 15);
    if (q_val > Q_MAX) begin
      sat_val = SAMPLE_BITS'(Q_MAX);
    end else if (q_val < Q_MIN) begin
      sat_val = SAMPLE_BITS'(Q_MIN);
    end else begin
      sat_val = q_val[SAMPLE_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_SWING;
      ST_SWING:  if (swing_last) state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_MIX;
      ST_MIX:    if (mix_last) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_DONE: load_out = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
        load_out = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dry_gain_r   <= DRY_GAIN_RST;
      wet_gain_r   <= WET_GAIN_RST;
      base_delay_r <= BASE_DELAY_RST;
      mod_depth_r  <= MOD_DEPTH_RST;
      lfo_step_r   <= LFO_STEP_RST;
      phase_r      <= '0;
      wp_r         <= '0;
      wrapped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DRY_GAIN:   dry_gain_r   <= cfg_data[GAIN_W-1:0];
          REG_WET_GAIN:   wet_gain_r   <= cfg_data[GAIN_W-1:0];
          REG_BASE_DELAY: base_delay_r <= cfg_data[BASE_W-1:0];
          REG_MOD_DEPTH:  mod_depth_r  <= cfg_data[DEPTH_W-1:0];
          REG_LFO_STEP:   lfo_step_r   <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_LOOKUP || state_r == ST_FETCH ||
          (state_r == ST_SWING && swing_last) || (state_r == ST_MIX && mix_last)) begin
        cnt_r <= '0;
      end else if (state_r == ST_SWING || state_r == ST_MIX) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (state_r == ST_ADDR) begin
        wp_r <= wp_r + ADDR_W'(1);
        if (wp_r == ADDR_W'(DELAY_LENGTH - 1)) begin
          wrapped_r <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_r + lfo_step_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_word.sample_in;
      last_r <= in_word.last_channel;
    end
    case (state_r)
      ST_LOOKUP: begin
        mag_r      <= qidx[QTR_W] ? QS_PEAK : QS_TAB[qidx[QTR_W-1:0]];
        neg_r      <= sidx[SINE_W-1];
        depth_sh_r <= mod_depth_r;
        prod_r     <= '0;
      end
      ST_SWING: begin
        prod_r     <= (prod_r << 1) + (depth_sh_r[DEPTH_W-1] ? PROD_W'(mag_r) : '0);
        depth_sh_r <= depth_sh_r << 1;
      end
      ST_ADDR: begin
        rd_ok_r <= rd_ok;
      end
      ST_FETCH: begin
        d_r      <= rd_ok_r ? rdata_r : '0;
        acc_r    <= '0;
        dry_sh_r <= dry_gain_r;
        wet_sh_r <= wet_gain_r;
      end
      ST_MIX: begin
        acc_r    <= (acc_r <<< 1) + mix_add;
        dry_sh_r <= dry_sh_r << 1;
        wet_sh_r <= wet_sh_r << 1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_word_r.sample_out <= sat_val;
      out_word_r.frame_done <= last_r;
    end
  end

  // delay line memory
  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      rdata_r    <= mem[rd_addr];
      mem[wp_r]  <= x_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- bench/chorus_checker.sv -----
`timescale 1ns / 1ps
module chorus_checker
  import cmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  cmd_in_t               in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  cmd_out_t              out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic signed [SAMPLE_BITS-1:0] sine_lut [SINE_ENTRIES];
  logic signed [SAMPLE_BITS-1:0] history [DELAY_LENGTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [PHASE_W-1:0] lfo_acc;
  logic [GAIN_W-1:0]  dry_gain;
  logic [GAIN_W-1:0]  wet_gain;
  logic [BASE_W-1:0]  base_delay;
  logic [DEPTH_W-1:0] mod_depth;
  logic [STEP_W-1:0]  lfo_step;
  cmd_out_t           mixed_words [$];

  // first quadrant of the sine, q30 polynomial scaled to q1.15
  function automatic int quarter_wave(longint unsigned u);
    longint unsigned u2;
    longint unsigned a;
    longint unsigned s;
    u2 = (u * u) >> 30;
    a  = 64'd172272;
    a  = 64'd5026997 - ((a * u2) >> 30);
    a  = 64'd85569306 - ((a * u2) >> 30);
    a  = 64'd693598670 - ((a * u2) >> 30);
    a  = 64'd1686629713 - ((a * u2) >> 30);
    s  = (a * u) >> 30;
    s  = (s * 64'd32767 + 64'd536870912) >> 30;
    return (s > 64'd32767) ? 32767 : int'(s);
  endfunction

  function automatic int sine_entry(int k);
    int quad;
    longint unsigned u;
    int v;
    quad = (4 * k) / SINE_ENTRIES;
    u    = 64'(4 * k - quad * SINE_ENTRIES);
    u    = (u << 30) / SINE_ENTRIES;
    if (quad % 2 == 1) begin
      u = (64'd1 << 30) - u;
    end
    v = quarter_wave(u);
    return (quad >= 2) ? -v : v;
  endfunction

  initial begin
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      sine_lut[k] = SAMPLE_BITS'(sine_entry(k));
    end
  end

  // one sample through the delay line, advancing pointer and lfo
  function automatic cmd_out_t chorus_next(cmd_in_t w);
    cmd_out_t r;
    int s;
    int swing;
    int dly;
    longint x;
    longint d;
    longint mix;
    logic [ADDR_W-1:0] rd;
    s = sine_lut[lfo_acc[PHASE_W-1 -: SINE_W]];
    if (s >= 0) begin
      swing = (int'(mod_depth) * s) >> 15;
    end else begin
      swing = -((int'(mod_depth) * -s) >> 15);
    end
    dly = int'(base_delay) + swing;
    if (dly < 0) begin
      dly = 0;
    end
    if (dly > DELAY_LENGTH - 1) begin
      dly = DELAY_LENGTH - 1;
    end
    rd = wr_ptr - ADDR_W'(dly);
    x  = $signed(w.sample_in);
    d  = history[rd];
    history[wr_ptr] = w.sample_in;
    wr_ptr = wr_ptr + 1'b1;
    mix = longint'(dry_gain) * x + longint'(wet_gain) * d;
    mix = (mix + 16384) >>> 15;
    if (mix > 32767) begin
      mix = 32767;
    end
    if (mix < -32768) begin
      mix = -32768;
    end
    r.sample_out = SAMPLE_BITS'(mix);
    r.frame_done = w.last_channel;
    lfo_acc = lfo_acc + lfo_step;
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < DELAY_LENGTH; i++) begin
        history[i] = '0;
      end
      wr_ptr     = '0;
      lfo_acc    = '0;
      dry_gain   = DRY_GAIN_RST;
      wet_gain   = WET_GAIN_RST;
      base_delay = BASE_DELAY_RST;
      mod_depth  = MOD_DEPTH_RST;
      lfo_step   = LFO_STEP_RST;
      mixed_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DRY_GAIN: begin
            dry_gain = cfg_data[GAIN_W-1:0];
          end
          REG_WET_GAIN: begin
            wet_gain = cfg_data[GAIN_W-1:0];
          end
          REG_BASE_DELAY: begin
            base_delay = cfg_data[BASE_W-1:0];
          end
          REG_MOD_DEPTH: begin
            mod_depth = cfg_data[DEPTH_W-1:0];
          end
          REG_LFO_STEP: begin
            lfo_step = cfg_data[STEP_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (mixed_words.size() == 0) begin
          $error("unexpected word: sample_out %0d frame_done %0b",
                 $signed(out_word.sample_out), out_word.frame_done);
          fail_count++;
        end else begin
          want = mixed_words.pop_front();
          if (out_word.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_word.sample_out));
            fail_count++;
          end
          if (out_word.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b",
                   want.frame_done, out_word.frame_done);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        mixed_words.push_back(chorus_next(in_word));
      end
    end
    pending = mixed_words.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import cmd_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_LFO_STEP + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_in_t               in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cmd_out_t              out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DRY_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  bit                    calm = 1'b0;
  bit                    long_hold = 1'b0;

  chorus_modulated_delay_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chorus_checker mix_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall before each word, one long hold when asked
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        n = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 9);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  <= '{sample_in: x, last_channel: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random junk above the register width
  function automatic logic [CFG_DATA_W-1:0] pad_bits(logic [CFG_DATA_W-1:0] v, int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (w >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << w) - 1'b1);
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] dry, logic [CFG_DATA_W-1:0] wet,
                            logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] depth,
                            logic [CFG_DATA_W-1:0] step);
    cfg_write(REG_DRY_GAIN, pad_bits(dry, GAIN_W));
    cfg_write(REG_WET_GAIN, pad_bits(wet, GAIN_W));
    cfg_write(REG_BASE_DELAY, pad_bits(base, BASE_W));
    cfg_write(REG_MOD_DEPTH, pad_bits(depth, DEPTH_W));
    cfg_write(REG_LFO_STEP, step);
    cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_level(int w);
    logic [CFG_DATA_W-1:0] top;
    top = (CFG_DATA_W'(1) << w) - 1'b1;
    case ($urandom_range(0, 3))
      0: begin
        return '0;
      end
      1: begin
        return top;
      end
      default: begin
        return $urandom() & top;
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: begin
        return $urandom_range(0, 1) ? 32'hffff : 32'h0;
      end
      1: begin
        return $urandom_range(0, 65535);
      end
      default: begin
        return $urandom_range(0, 32768);
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0: begin
        return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      end
      1: begin
        return $urandom();
      end
      default: begin
        return $urandom_range(0, 32'h0010_0000);
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      1, 2, 3, 4: begin
        return SAMPLE_BITS'($urandom());
      end
      default: begin
        return SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
      end
    endcase
  endfunction

  initial begin
    int chans;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, sample extremes
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh3039, 1'b1);

    // rounding ties go up
    settle();
    set_config(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
    send_sample(16'sh4000, 1'b0);
    send_sample(-16'sh4000, 1'b1);
    send_sample(-16'sh4001, 1'b0);
    send_sample(16'sh3fff, 1'b1);

    // zero delay, full gains saturate
    settle();
    set_config(32'hffff, 32'hffff, 32'd0, 32'd0, 32'd0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);

    // delay clamped high at the sine peak
    settle();
    set_config(32'h8000, 32'h8000, 32'd2047, 32'd1023, 32'h4000_0000);
    repeat (4) send_sample(pick_sample(), 1'b1);

    // delay clamped low at the sine trough
    settle();
    set_config(32'h4000, 32'hffff, 32'd0, 32'd1023, 32'hc000_0000);
    repeat (4) send_sample(pick_sample(), 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      set_config(pick_gain(), pick_gain(), pick_level(BASE_W), pick_level(DEPTH_W),
                 pick_step());
      calm = (p % 4 == 1);
      if (p == 2) begin
        long_hold = 1'b1;
      end
      chans = $urandom_range(1, 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_sample(), (i % chans) == chans - 1);
      end
    end
    calm = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/cmd_pkg.sv
src/chorus_modulated_delay_unit.sv
bench/chorus_checker.sv
bench/tb.sv
